// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL in this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SLE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sle assertion failed");

// Check that a condition never holds on a rising edge outside reset.
`define SLE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sle forbidden condition seen");

`endif

// File: rtl/core/sle_pkg.sv
package sle_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [7:0] BYTE_NL    = 8'h0A;
    localparam logic [7:0] BYTE_DQ    = 8'h22;
    localparam logic [7:0] BYTE_BS    = 8'h5C;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;
    localparam logic [7:0] TWO_DIGIT  = 8'd10;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } out_item_t;

    // Escape sequence of a single byte: up to four output bytes.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } esc_seq_t;

    // One queued transaction: all output bytes caused by one input item.
    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [3:0]      count;
        logic            string_end;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= BYTE_ZERO) && (b <= BYTE_NINE);
    endfunction

    function automatic esc_seq_t escape_byte(input logic [7:0] c, input logic next_digit);
        esc_seq_t   s;
        logic [1:0] tens;
        logic [4:0] ones;
        logic [7:0] tens_chr;
        logic [7:0] ones_chr;
        s.bytes = '0;
        s.count = 3'd1;
        if (c[4:0] >= 5'd30)
            tens = 2'd3;
        else if (c[4:0] >= 5'd20)
            tens = 2'd2;
        else if (c[4:0] >= 5'd10)
            tens = 2'd1;
        else
            tens = 2'd0;
        ones     = c[4:0] - 5'({3'b000, tens} * 5'd10);
        tens_chr = BYTE_ZERO + {6'b000000, tens};
        ones_chr = BYTE_ZERO + {3'b000, ones};
        if ((c == BYTE_NL) || (c == BYTE_DQ) || (c == BYTE_BS))
        begin
            s.bytes[0] = BYTE_BS;
            s.bytes[1] = c;
            s.count    = 3'd2;
        end
        else if (c < CTRL_LIMIT)
        begin
            s.bytes[0] = BYTE_BS;
            if (next_digit)
            begin
                s.bytes[1] = BYTE_ZERO;
                s.bytes[2] = tens_chr;
                s.bytes[3] = ones_chr;
                s.count    = 3'd4;
            end
            else if (c >= TWO_DIGIT)
            begin
                s.bytes[1] = tens_chr;
                s.bytes[2] = ones_chr;
                s.count    = 3'd3;
            end
            else
            begin
                s.bytes[1] = ones_chr;
                s.count    = 3'd2;
            end
        end
        else
        begin
            s.bytes[0] = c;
            s.count    = 3'd1;
        end
        return s;
    endfunction

endpackage

// File: rtl/core/string_literal_escaper_unit.sv
// Output bytes leave through the job queue and the single output register.
// Throughput: one input transaction per cycle while the queue has room and each
//   yields at most one byte; output leaves at one byte per cycle while not stalled.
// A 4-entry job queue absorbs escape bursts of up to 6 bytes per input.
// Reset (rst_n, async, active low) drops the held byte, queue and output register.
module string_literal_escaper_unit
    import sle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    // Front to queue: classified jobs, one per input that produces output.
    logic    push;
    job_t    push_job;
    // Queue to back: head job and occupancy.
    logic    pop;
    job_t    head;
    q_stat_t q_stat;

    // Hold the previous byte, escape it once the lookahead arrives, and
    // flush the end-of-string byte with a zero lookahead.
    sle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_stat     (q_stat),
        .push       (push),
        .job        (push_job)
    );

    // Decouple the classifier from the byte sequencer.
    sle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // Advance through each job one byte per transaction; drop the job on its last byte.
    sle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_stat       (q_stat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: rtl/core/sle_front.sv
module sle_front
    import sle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  in_item_t item,
    input  q_stat_t  q_stat,
    output logic     push,
    output job_t     job
);

    logic [7:0] held_byte_reg;
    logic [7:0] held_byte_next;
    logic       held_valid_reg;
    logic       held_valid_next;
    logic       accept;
    esc_seq_t   seq_a;
    esc_seq_t   seq_b;
    logic [2:0] na;
    logic [2:0] nb;

    assign item_ready = !q_stat.full;
    assign accept     = item_valid && item_ready;

    // Escape the held byte against the new lookahead; the end byte sees zero.
    assign seq_a = escape_byte(held_byte_reg, is_digit(item.in_byte));
    assign seq_b = escape_byte(item.in_byte, 1'b0);
    assign na    = held_valid_reg ? seq_a.count : 3'd0;
    assign nb    = item.string_end ? seq_b.count : 3'd0;

    always_comb
    begin
        logic [3:0] j;
        job.count      = {1'b0, na} + {1'b0, nb};
        job.string_end = item.string_end;
        for (int i = 0; i < 8; i++)
        begin
            j = 4'(i) - {1'b0, na};
            if (4'(i) < {1'b0, na})
                job.bytes[i] = seq_a.bytes[i[1:0]];
            else if (j < 4'd4)
                job.bytes[i] = seq_b.bytes[j[1:0]];
            else
                job.bytes[i] = '0;
        end
    end

    assign push = accept && (job.count != 4'd0);

    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        if (accept)
        begin
            held_byte_next  = item.string_end ? 8'd0 : item.in_byte;
            held_valid_next = !item.string_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

// File: rtl/core/sle_queue.sv
`include "assert_macros.svh"

module sle_queue
    import sle_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head,
    output q_stat_t q_stat
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg;
    logic [QPTR_W:0]   cnt_next;

    assign q_stat.full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `SLE_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && q_stat.full)
    `SLE_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && q_stat.empty)
    `SLE_ASSERT(a_ptr_track, clk, rst_n, (wr_ptr_reg - rd_ptr_reg) == cnt_reg[QPTR_W-1:0])

endmodule

// File: rtl/core/sle_back.sv
`include "assert_macros.svh"

module sle_back
    import sle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      head,
    input  q_stat_t   q_stat,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;
    out_item_t  out_item_next;
    logic       load;
    logic       at_end;

    assign load   = !q_stat.empty && (!out_valid_reg || result_ready);
    assign at_end = ({1'b0, idx_reg} == (head.count - 4'd1));
    assign pop    = load && at_end;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_item_next  = out_item_reg;
        if (load)
        begin
            out_valid_next            = 1'b1;
            out_item_next.out_byte    = head.bytes[idx_reg];
            out_item_next.run_last    = at_end;
            out_item_next.string_done = at_end && head.string_end;
            idx_next                  = at_end ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    `SLE_ASSERT(a_idx_in_job, clk, rst_n, !q_stat.empty |-> ({1'b0, idx_reg} < head.count))

endmodule

// File: tb/tb_string_literal_escaper_unit.sv
`timescale 1ns / 1ps

module tb_string_literal_escaper_unit;
    import sle_pkg::*;

    localparam int RANDOM_ITEMS   = 355;
    localparam int MAX_GAP        = 17;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int MAX_PRINTS     = 60;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    string_literal_escaper_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Predictor state: the byte that still waits for its lookahead.
    logic [7:0] pending_byte  = 8'h00;
    logic       pending_valid = 1'b0;

    // Escaped output bytes expected from the block, oldest first.
    out_item_t  expected_escapes [$];

    int mismatches   = 0;
    int stall_cycles = 0;

    // Idle-free stretches on each side; toggled at random.
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    // Directed stimulus table. A row with its text typed in carries the exact
    // escaped bytes it must produce; other rows go through the predictor.
    in_item_t   dir_items [$];
    bit         dir_typed [$];
    string      dir_text  [$];

    task automatic flag_mismatch(input string what);
        if (mismatches < MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic add_row(input logic [7:0] b, input logic e, input bit typed,
                           input string txt);
        in_item_t x;
        x.in_byte    = b;
        x.string_end = e;
        dir_items.insert(dir_items.size(), x);
        dir_typed.insert(dir_typed.size(), typed);
        dir_text.insert(dir_text.size(), txt);
    endtask

    // Escaped text of one byte, given the byte that follows it. Escaped text
    // never contains a zero byte, so a string holds it safely.
    function automatic string escape_char(input logic [7:0] c, input logic [7:0] after);
        if ((c == BYTE_NL) || (c == BYTE_DQ) || (c == BYTE_BS))
            return $sformatf("\\%c", c);
        if (c < CTRL_LIMIT)
        begin
            // Pad to three digits so a following digit cannot extend the code.
            if ((after >= BYTE_ZERO) && (after <= BYTE_NINE))
                return $sformatf("\\%03d", c);
            return $sformatf("\\%0d", c);
        end
        return $sformatf("%c", c);
    endfunction

    // Advance the predictor by one accepted transaction and return its text.
    task automatic predict_escape(input in_item_t x, output string txt);
        txt = "";
        if (pending_valid)
            txt = escape_char(pending_byte, x.in_byte);
        if (x.string_end)
        begin
            // End of string: flush at once with a zero lookahead.
            txt           = {txt, escape_char(x.in_byte, 8'h00)};
            pending_byte  = 8'h00;
            pending_valid = 1'b0;
        end
        else
        begin
            pending_byte  = x.in_byte;
            pending_valid = 1'b1;
        end
    endtask

    // Turn escaped text into expected output transactions with their flags.
    task automatic queue_escapes(input string txt, input logic ends_string);
        out_item_t e;
        for (int i = 0; i < txt.len(); i++)
        begin
            e.out_byte    = txt[i];
            e.run_last    = (i == txt.len() - 1);
            e.string_done = e.run_last && ends_string;
            expected_escapes.insert(expected_escapes.size(), e);
        end
    endtask

    // Drive one input transaction after a random gap and return at the edge
    // where it is accepted. Valid is only lowered when a gap follows.
    task automatic send_item(input in_item_t x);
        int gap;
        if ($urandom_range(0, 29) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= x;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // Send, predict and queue one transaction.
    task automatic run_item(input in_item_t x);
        string txt;
        send_item(x);
        predict_escape(x, txt);
        queue_escapes(txt, x.string_end);
    endtask

    // Random byte, weighted toward the cases that escape or pad.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0, 1:
                return 8'($urandom_range(0, 31));
            2:
            begin
                case ($urandom_range(0, 2))
                    0:       return BYTE_NL;
                    1:       return BYTE_DQ;
                    default: return BYTE_BS;
                endcase
            end
            3, 4:
                return 8'($urandom_range(BYTE_ZERO, BYTE_NINE));
            5:
                return 8'($urandom_range(32, 126));
            6:
                return 8'($urandom_range(128, 255));
            default:
                return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Hold the drain: pause the sender until every expected byte has come.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_escapes.size() != 0)
            @(posedge clk);
    endtask

    // Sender: reset, directed table, random strings, drain, verdict.
    initial
    begin
        string    txt;
        in_item_t x;
        int       sent;
        int       len;

        // One-byte string right after reset.
        add_row(8'h41, 1'b1, 1'b1, "A");
        // Held NUL padded by a digit lookahead.
        add_row(8'h00, 1'b0, 1'b1, "");
        add_row(8'h35, 1'b1, 1'b1, "\\0005");
        // Two-digit code padded by '9', then the digit itself.
        add_row(8'h1F, 1'b0, 1'b1, "");
        add_row(8'h39, 1'b0, 1'b1, "\\031");
        add_row(8'h0A, 1'b0, 1'b1, "9");
        // Newline, quote and backslash escape as themselves.
        add_row(8'h22, 1'b0, 1'b1, "\\\n");
        add_row(8'h5C, 1'b0, 1'b1, "\\\"");
        // Final control byte: zero lookahead, so no padding.
        add_row(8'h1F, 1'b1, 1'b1, "\\\\\\31");
        add_row(8'hFF, 1'b1, 1'b0, "");
        add_row(8'h00, 1'b1, 1'b1, "\\0");
        add_row(8'h09, 1'b0, 1'b1, "");
        add_row(8'h30, 1'b0, 1'b1, "\\009");
        add_row(8'h0A, 1'b1, 1'b1, "0\\\n");
        // Longest burst: two control codes from one transaction.
        add_row(8'h1F, 1'b0, 1'b1, "");
        add_row(8'h1F, 1'b1, 1'b1, "\\31\\31");
        add_row(8'h10, 1'b0, 1'b0, "");
        add_row(8'h30, 1'b1, 1'b0, "");
        add_row(8'h80, 1'b0, 1'b0, "");
        add_row(8'h7F, 1'b1, 1'b0, "");
        // First byte that passes unchanged.
        add_row(8'h20, 1'b1, 1'b1, " ");
        // Lookahead just outside the digit range on either side.
        add_row(8'h1F, 1'b0, 1'b1, "");
        add_row(8'h3A, 1'b1, 1'b1, "\\31:");
        add_row(8'h05, 1'b0, 1'b1, "");
        add_row(8'h2F, 1'b1, 1'b1, "\\5/");

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < dir_items.size(); i++)
        begin
            send_item(dir_items[i]);
            predict_escape(dir_items[i], txt);
            if (dir_typed[i])
                queue_escapes(dir_text[i], dir_items[i].string_end);
            else
                queue_escapes(txt, dir_items[i].string_end);
        end

        wait_drained();

        // Random strings; mostly a few bytes long, some single-byte.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
            for (int j = 0; j < len; j++)
            begin
                x.in_byte    = pick_byte();
                x.string_end = (j == len - 1);
                run_item(x);
                sent++;
            end
            // Drain once mid-run with a string boundary just behind.
            if ((sent >= RANDOM_ITEMS / 2) && (sent - len < RANDOM_ITEMS / 2))
                wait_drained();
        end

        item_valid <= 1'b0;
        while (expected_escapes.size() != 0)
            @(posedge clk);
        // Keep the clock running to catch stray output.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS string_literal_escaper_unit");
        else
            $display("FAIL string_literal_escaper_unit");
        $finish;
    end

    // Receiver: stall a random number of cycles before taking each byte.
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                recv_calm = !recv_calm;
            stall = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    // Compare every accepted output transaction with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_escapes.size() == 0)
                flag_mismatch($sformatf("unexpected output byte %02h", result.out_byte));
            else
            begin
                e = expected_escapes.pop_front();
                if (result.out_byte !== e.out_byte)
                    flag_mismatch($sformatf("out_byte %02h, expected %02h",
                                            result.out_byte, e.out_byte));
                if (result.run_last !== e.run_last)
                    flag_mismatch($sformatf("run_last %b, expected %b on byte %02h",
                                            result.run_last, e.run_last, e.out_byte));
                if (result.string_done !== e.string_done)
                    flag_mismatch($sformatf("string_done %b, expected %b on byte %02h",
                                            result.string_done, e.string_done,
                                            e.out_byte));
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL string_literal_escaper_unit");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
